// File: hw/rtl/ota_pkg.sv
// shared types, constants and the crc-16/modbus byte update for the download receiver
package ota_pkg;

    localparam int OTA_FRAME_BYTES = 1024;
    localparam int LEN_W           = 17;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [23:0] MAX24      = 24'hFFFFFF;
    localparam logic [7:0]  FUNC_WRITE = 8'h02;
    localparam logic [7:0]  SUB_DATA   = 8'h01;
    localparam int          MIN_FRAME  = 9;
    localparam int          PAYLOAD_POS = 7;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;

    localparam logic [1:0] CFG_STATION  = 2'd0;
    localparam logic [1:0] CFG_EXP_SIZE = 2'd1;
    localparam logic [1:0] CFG_EXP_CRC  = 2'd2;
    localparam logic [1:0] CFG_LIMIT    = 2'd3;

    localparam logic [7:0]  RST_STATION = 8'd1;
    localparam logic [23:0] RST_LIMIT   = 24'd262144;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_NACK    = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_REPORT  = 3'd4
    } ota_kind_t;

    typedef struct packed {
        logic [7:0]  station_id;
        logic [23:0] expected_size;
        logic [15:0] expected_crc;
        logic [23:0] image_limit;
    } ota_cfg_t;

    typedef struct packed {
        ota_kind_t   kind;
        logic [23:0] image_offset;
        logic [7:0]  data_byte;
        logic [15:0] sequence_res;
        logic [7:0]  reply_station;
        logic [23:0] image_length;
        logic [15:0] image_crc;
        logic        image_ok;
    } ota_result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/ota_cfg_regs.sv
// configuration register bank: station id, expected image size and crc, size limit
module ota_cfg_regs
    import ota_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output ota_cfg_t    cfg
);

    ota_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.station_id    <= RST_STATION;
            cfg_reg.expected_size <= '0;
            cfg_reg.expected_crc  <= '0;
            cfg_reg.image_limit   <= RST_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STATION:  cfg_reg.station_id    <= cfg_data[7:0];
                CFG_EXP_SIZE: cfg_reg.expected_size <= cfg_data;
                CFG_EXP_CRC:  cfg_reg.expected_crc  <= cfg_data[15:0];
                CFG_LIMIT:    cfg_reg.image_limit   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/ota_frame_engine.sv
// input register, frame parsing, crc checking and session state
module ota_frame_engine
    import ota_pkg::*;
#(
    parameter int FRAME_BYTES = OTA_FRAME_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  ota_cfg_t    cfg,
    input  logic        res_ready,
    output logic        res_valid,
    output ota_result_t res
);

    localparam int POS_W = $clog2(FRAME_BYTES + 2);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_OVER = POS_W'(FRAME_BYTES + 1);

    // input request register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic [1:0] in_mode_reg;
    logic       in_last_reg;
    logic       fire;

    // session and frame state
    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      fcrc_reg, fcrc_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       sub_reg, sub_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      plen_reg, plen_next;
    logic [23:0]      acc_reg, acc_next;
    logic [15:0]      commit_reg, commit_next;
    logic [15:0]      pend_reg, pend_next;
    logic [7:0]       hold_a_reg, hold_a_next;
    logic [7:0]       hold_b_reg, hold_b_next;

    logic             restart;
    logic             has_res;
    logic [15:0]      crc_fin;
    logic [15:0]      recv_crc;
    logic             good;
    logic             verify_ok;
    logic [24:0]      acc_sum;
    logic [24:0]      off_sum;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] plen_ext;

    assign fire     = in_vld_reg && res_ready;
    assign s_tready = !in_vld_reg || res_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    assign pos_ext   = LEN_W'(pos_reg);
    assign plen_ext  = LEN_W'(plen_reg);
    assign crc_fin   = (pos_reg >= POS_W'(2)) ? crc16_update(fcrc_reg, hold_b_reg) : fcrc_reg;
    assign recv_crc  = {in_byte_reg, hold_a_reg};
    assign acc_sum   = {1'b0, acc_reg} + {9'd0, plen_reg};
    assign off_sum   = {1'b0, acc_reg} + 25'(pos_reg - POS_W'(PAYLOAD_POS));
    assign good      = (pos_ext + LEN_W'(1) >= LEN_W'(MIN_FRAME))
                       && (crc_fin == recv_crc)
                       && (func_reg == FUNC_WRITE) && (sub_reg == SUB_DATA)
                       && (pos_ext + LEN_W'(1) >= LEN_W'(MIN_FRAME) + plen_ext);

    always_comb begin
        if (cfg.expected_crc != '0 && cfg.expected_size != '0) begin
            verify_ok = (commit_reg == cfg.expected_crc) && (acc_reg == cfg.expected_size);
        end else begin
            verify_ok = (acc_reg != '0) && (acc_reg <= cfg.image_limit);
        end
    end

    always_comb begin
        active_next = active_reg;
        pos_next    = pos_reg;
        fcrc_next   = fcrc_reg;
        func_next   = func_reg;
        sub_next    = sub_reg;
        seq_next    = seq_reg;
        plen_next   = plen_reg;
        acc_next    = acc_reg;
        commit_next = commit_reg;
        pend_next   = pend_reg;
        hold_a_next = hold_a_reg;
        hold_b_next = hold_b_reg;
        restart     = 1'b0;
        has_res     = 1'b0;
        res         = '0;

        if (fire) begin
            case (in_mode_reg)
                MODE_START: begin
                    if (!active_reg) begin
                        active_next = 1'b1;
                        acc_next    = '0;
                        commit_next = CRC_INIT;
                        restart     = 1'b1;
                    end
                end
                MODE_TIMEOUT: begin
                    if (active_reg) begin
                        restart = 1'b1;
                        if (acc_reg != '0) begin
                            has_res          = 1'b1;
                            res.kind         = KIND_REPORT;
                            res.image_length = acc_reg;
                            res.image_crc    = commit_reg;
                            res.image_ok     = verify_ok;
                            active_next      = 1'b0;
                        end
                    end
                end
                MODE_BYTE: begin
                    if (active_reg) begin
                        if (in_last_reg) begin
                            has_res = 1'b1;
                            restart = 1'b1;
                            if (pos_reg >= POS_FULL) begin
                                res.kind = KIND_DROP;
                            end else begin
                                res.reply_station = cfg.station_id;
                                if (good) begin
                                    acc_next         = acc_sum[24] ? MAX24 : acc_sum[23:0];
                                    commit_next      = pend_reg;
                                    res.kind         = KIND_ACK;
                                    res.sequence_res = seq_reg;
                                end else begin
                                    res.kind = KIND_NACK;
                                end
                            end
                        end else if (pos_reg >= POS_FULL) begin
                            pos_next = POS_OVER;
                        end else begin
                            if (pos_reg >= POS_W'(2)) begin
                                fcrc_next = crc16_update(fcrc_reg, hold_b_reg);
                            end
                            if (pos_reg == POS_W'(1)) func_next = in_byte_reg;
                            if (pos_reg == POS_W'(2)) sub_next = in_byte_reg;
                            if (pos_reg == POS_W'(3)) seq_next = {in_byte_reg, seq_reg[7:0]};
                            if (pos_reg == POS_W'(4)) seq_next = {seq_reg[15:8], in_byte_reg};
                            if (pos_reg == POS_W'(5)) plen_next = {in_byte_reg, plen_reg[7:0]};
                            if (pos_reg == POS_W'(6)) plen_next = {plen_reg[15:8], in_byte_reg};
                            hold_b_next = hold_a_reg;
                            hold_a_next = in_byte_reg;
                            pos_next    = pos_reg + POS_W'(1);
                            if (pos_reg >= POS_W'(PAYLOAD_POS)
                                && pos_ext < LEN_W'(PAYLOAD_POS) + plen_ext
                                && func_reg == FUNC_WRITE && sub_reg == SUB_DATA) begin
                                pend_next        = crc16_update(pend_reg, in_byte_reg);
                                has_res          = 1'b1;
                                res.kind         = KIND_PAYLOAD;
                                res.image_offset = off_sum[24] ? MAX24 : off_sum[23:0];
                                res.data_byte    = in_byte_reg;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            pos_next    = '0;
            fcrc_next   = CRC_INIT;
            func_next   = '0;
            sub_next    = '0;
            seq_next    = '0;
            plen_next   = '0;
            hold_a_next = '0;
            hold_b_next = '0;
            pend_next   = commit_next;
        end
    end

    assign res_valid = has_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            active_reg <= 1'b0;
            pos_reg    <= '0;
            fcrc_reg   <= CRC_INIT;
            func_reg   <= '0;
            sub_reg    <= '0;
            seq_reg    <= '0;
            plen_reg   <= '0;
            acc_reg    <= '0;
            commit_reg <= CRC_INIT;
            pend_reg   <= CRC_INIT;
            hold_a_reg <= '0;
            hold_b_reg <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            active_reg <= active_next;
            pos_reg    <= pos_next;
            fcrc_reg   <= fcrc_next;
            func_reg   <= func_next;
            sub_reg    <= sub_next;
            seq_reg    <= seq_next;
            plen_reg   <= plen_next;
            acc_reg    <= acc_next;
            commit_reg <= commit_next;
            pend_reg   <= pend_next;
            hold_a_reg <= hold_a_next;
            hold_b_reg <= hold_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_mode_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// File: hw/rtl/ota_out_stage.sv
// result register that holds one result until the downstream side takes it
module ota_out_stage
    import ota_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         res_valid,
    input  ota_result_t  res,
    output logic         res_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    output logic [2:0]   m_tuser
);

    logic        out_vld_reg, out_vld_next;
    ota_result_t out_reg;

    assign res_ready    = !out_vld_reg || m_tready;
    assign out_vld_next = res_valid || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.image_ok, out_reg.image_crc, out_reg.image_length,
                       out_reg.reply_station, out_reg.sequence_res, out_reg.data_byte,
                       out_reg.image_offset};

endmodule

// File: hw/rtl/ota_packet_receiver.sv
// top level of the framed firmware download receiver
//
// s_ channel: one request per received frame byte or event. s_tuser selects
// byte (0), idle timeout (1) or start of a new download (2); s_tdata is the
// byte and s_tlast marks the last byte of a frame.
// m_ channel: at most one result per request. m_tuser is the kind (payload,
// ack, nack, drop, final report); m_tdata carries offset, byte, sequence,
// station, image length, image crc and the ok flag.
// cfg_ channel: register writes, always ready; the user must write them only while the
// block is idle, which the block itself does not enforce. A request passes the input
// register, then one pass of crc update and field decode into the result register,
// which drives m_tvalid. Throughput is one request per cycle while the m_ side is
// not stalled; the byte-wide crc step sets the path.
// Reset clears the session (inactive) and loads register defaults.
// A stalled m_ side holds its result; the input register still takes one
// more request, then s_tready drops until the result is taken.
module ota_packet_receiver
    import ota_pkg::*;
#(
    parameter int FRAME_BYTES = OTA_FRAME_BYTES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    input  logic [1:0]   s_tuser,   // mode
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // image_offset, data_byte, sequence_res, reply_station,
                                    // image_length, image_crc, image_ok
    output logic [2:0]   m_tuser,   // kind
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    ota_cfg_t    cfg;
    ota_result_t res;
    logic        res_valid;
    logic        res_ready;

    assign cfg_ready = 1'b1;

    ota_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ota_frame_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg       (cfg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    ota_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a final report is only given for a nonzero image
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REPORT |-> m_tdata[79:56] != 24'd0)
        else $error("report with zero image length");

    // payload results carry only offset and byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[103:32] == 72'd0)
        else $error("payload result with stray fields");

    // only ack and nack carry a station address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ACK && m_tuser != KIND_NACK |-> m_tdata[55:48] == 8'd0)
        else $error("station address on wrong result kind");

    // no result can appear in the cycle after reset
    assert property (@(posedge aclk) disable iff (!aresetn) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: tb/tb_ota_packet_receiver.sv
// self-checking testbench for the framed firmware download receiver, with a local predictor
module tb_ota_packet_receiver;
    import ota_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAME_MAX    = OTA_FRAME_BYTES;
    localparam int          DRAIN_CYCLES = 6;
    localparam logic [1:0]  MODE_SPARE   = 2'd3;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;
    logic [1:0]   s_tuser   = MODE_BYTE;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_STATION;
    logic [23:0]  cfg_data  = '0;

    ota_packet_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register copies
    logic [7:0]  reg_station  = RST_STATION;
    logic [23:0] reg_exp_size = '0;
    logic [15:0] reg_exp_crc  = '0;
    logic [23:0] reg_limit    = RST_LIMIT;

    // download and frame state
    logic        dl_active    = 1'b0;
    int          frm_pos      = 0;
    logic [15:0] frm_crc      = CRC_INIT;
    logic [7:0]  frm_func     = '0;
    logic [7:0]  frm_sub      = '0;
    logic [15:0] frm_seq      = '0;
    logic [15:0] frm_len      = '0;
    logic [7:0]  hold_a       = '0;
    logic [7:0]  hold_b       = '0;
    logic [23:0] img_bytes    = '0;
    logic [15:0] img_crc_done = CRC_INIT;
    logic [15:0] img_crc_pend = CRC_INIT;

    ota_result_t result_q[$];
    logic [7:0]  frame_buf[$];
    int          sent_count     = 0;
    int          mismatch_count = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[k]) c = {1'b0, c[15:1]} ^ CRC_POLY;
            else c = {1'b0, c[15:1]};
        end
        return c;
    endfunction

    function automatic void restart_frame();
        frm_pos      = 0;
        frm_crc      = CRC_INIT;
        frm_func     = '0;
        frm_sub      = '0;
        frm_seq      = '0;
        frm_len      = '0;
        hold_a       = '0;
        hold_b       = '0;
        img_crc_pend = img_crc_done;
    endfunction

    function automatic void predict_request(input logic [1:0] mode, input logic [7:0] b,
                                            input logic last);
        ota_result_t r;
        logic [15:0] wire_crc;
        int unsigned sum;
        int          p;
        r = '0;
        if (mode == MODE_START) begin
            if (!dl_active) begin
                dl_active    = 1'b1;
                img_bytes    = '0;
                img_crc_done = CRC_INIT;
                restart_frame();
            end
        end else if (mode == MODE_TIMEOUT && dl_active) begin
            restart_frame();
            if (img_bytes != 0) begin
                r.kind         = KIND_REPORT;
                r.image_length = img_bytes;
                r.image_crc    = img_crc_done;
                if (reg_exp_crc != 0 && reg_exp_size != 0)
                    r.image_ok = (img_crc_done == reg_exp_crc) && (img_bytes == reg_exp_size);
                else
                    r.image_ok = (img_bytes <= reg_limit);
                result_q.push_back(r);
                dl_active = 1'b0;
            end
        end else if (mode == MODE_BYTE && dl_active) begin
            if (last) begin
                if (frm_pos + 1 > FRAME_MAX) begin
                    r.kind = KIND_DROP;
                end else begin
                    if (frm_pos >= 2) frm_crc = crc_step(frm_crc, hold_b);
                    wire_crc = {b, hold_a};
                    if (frm_pos + 1 >= MIN_FRAME && frm_crc == wire_crc && frm_func == FUNC_WRITE
                            && frm_sub == SUB_DATA && frm_pos + 1 >= MIN_FRAME + frm_len) begin
                        sum          = img_bytes + frm_len;
                        img_bytes    = (sum > MAX24) ? MAX24 : sum[23:0];
                        img_crc_done = img_crc_pend;
                        r.kind         = KIND_ACK;
                        r.sequence_res = frm_seq;
                    end else begin
                        r.kind = KIND_NACK;
                    end
                    r.reply_station = reg_station;
                end
                restart_frame();
                result_q.push_back(r);
            end else if (frm_pos >= FRAME_MAX) begin
                frm_pos = FRAME_MAX + 1;
            end else begin
                p = frm_pos;
                if (p >= 2) frm_crc = crc_step(frm_crc, hold_b);
                case (p)
                    1: frm_func = b;
                    2: frm_sub = b;
                    3: frm_seq[15:8] = b;
                    4: frm_seq[7:0] = b;
                    5: frm_len[15:8] = b;
                    6: frm_len[7:0] = b;
                    default: ;
                endcase
                hold_b  = hold_a;
                hold_a  = b;
                frm_pos = p + 1;
                if (p >= PAYLOAD_POS && p < PAYLOAD_POS + frm_len && frm_func == FUNC_WRITE
                        && frm_sub == SUB_DATA) begin
                    img_crc_pend   = crc_step(img_crc_pend, b);
                    sum            = img_bytes + (p - PAYLOAD_POS);
                    r.kind         = KIND_PAYLOAD;
                    r.image_offset = (sum > MAX24) ? MAX24 : sum[23:0];
                    r.data_byte    = b;
                    result_q.push_back(r);
                end
            end
        end
    endfunction

    function automatic void check_field(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t ns %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        ota_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t ns unexpected result: expected none, actual kind %0d data %0h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = result_q.pop_front();
                check_field("kind", 24'(want.kind), 24'(m_tuser));
                check_field("image_offset", want.image_offset, m_tdata[23:0]);
                check_field("data_byte", 24'(want.data_byte), 24'(m_tdata[31:24]));
                check_field("sequence_res", 24'(want.sequence_res), 24'(m_tdata[47:32]));
                check_field("reply_station", 24'(want.reply_station), 24'(m_tdata[55:48]));
                check_field("image_length", want.image_length, m_tdata[79:56]);
                check_field("image_crc", 24'(want.image_crc), 24'(m_tdata[95:80]));
                check_field("image_ok", 24'(want.image_ok), 24'(m_tdata[96]));
            end
        end
    end

    task automatic send_req(input logic [1:0] mode, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_request(mode, b, last);
        sent_count++;
    endtask

    task automatic send_event(input logic [1:0] mode);
        send_req(mode, 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_STATION:  reg_station  = val[7:0];
            CFG_EXP_SIZE: reg_exp_size = val;
            CFG_EXP_CRC:  reg_exp_crc  = val[15:0];
            CFG_LIMIT:    reg_limit    = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] station, input logic [23:0] size,
                            input logic [15:0] crc, input logic [23:0] limit);
        push_reg(CFG_STATION, 24'(station));
        push_reg(CFG_EXP_SIZE, size);
        push_reg(CFG_EXP_CRC, 24'(crc));
        push_reg(CFG_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_frame(input logic [7:0] fn, input logic [7:0] sub,
                               input logic [15:0] seq, input logic [15:0] len,
                               input int body, input logic [15:0] crc_flip);
        logic [15:0] c;
        frame_buf.delete();
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(fn);
        frame_buf.push_back(sub);
        frame_buf.push_back(seq[15:8]);
        frame_buf.push_back(seq[7:0]);
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(len[7:0]);
        for (int k = 0; k < body; k++) frame_buf.push_back(8'($urandom));
        c = CRC_INIT;
        foreach (frame_buf[k]) c = crc_step(c, frame_buf[k]);
        c ^= crc_flip;
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic build_raw(input int n);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(8'($urandom));
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_req(MODE_BYTE, frame_buf[k], k == frame_buf.size() - 1);
    endtask

    task automatic good_frame(input logic [15:0] seq, input int len, input int filler);
        build_frame(FUNC_WRITE, SUB_DATA, seq, 16'(len), len + filler, 16'h0000);
        send_frame();
    endtask

    // frame cut off by an idle timeout
    task automatic cut_frame(input int keep);
        for (int k = 0; k < keep && k < frame_buf.size(); k++)
            send_req(MODE_BYTE, frame_buf[k], 1'b0);
        send_event(MODE_TIMEOUT);
    endtask

    function automatic logic [23:0] rand_limit();
        case ($urandom_range(3))
            0: return 24'd1;
            1: return MAX24;
            2: return 24'($urandom_range(64, 1));
            default: return 24'($urandom_range(24'hFFFFFF, 1));
        endcase
    endfunction

    function automatic logic [7:0] rand_station();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        int len;
        int filler;
        len    = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(12);
        filler = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        case ($urandom_range(11))
            0: begin
                build_frame(8'($urandom), SUB_DATA, 16'($urandom), 16'(len), len, 16'h0000);
                send_frame();
            end
            1: begin
                build_frame(FUNC_WRITE, 8'($urandom), 16'($urandom), 16'(len), len, 16'h0000);
                send_frame();
            end
            2: begin
                build_frame(FUNC_WRITE, SUB_DATA, 16'($urandom), 16'(len), len + filler,
                            16'($urandom_range(16'hFFFF, 1)));
                send_frame();
            end
            3: begin
                build_frame(FUNC_WRITE, SUB_DATA, 16'($urandom), 16'(len + $urandom_range(4, 1)),
                            len, 16'h0000);
                send_frame();
            end
            4: begin
                build_raw($urandom_range(8, 1));
                send_frame();
            end
            5: begin
                build_frame(FUNC_WRITE, SUB_DATA, 16'($urandom), 16'(len), len, 16'h0000);
                if ($urandom_range(2) == 0) cut_frame($urandom_range(frame_buf.size() - 1));
                else send_frame();
            end
            default: good_frame(16'($urandom), len, filler);
        endcase
    endtask

    task automatic test_idle_session();
        send_req(MODE_BYTE, 8'hFF, 1'b1);
        send_req(MODE_BYTE, 8'h00, 1'b0);
        send_event(MODE_TIMEOUT);
        send_event(MODE_SPARE);
        send_event(MODE_START);
        // timeout with nothing accepted keeps the download open
        send_event(MODE_TIMEOUT);
        send_event(MODE_START);
        send_event(MODE_SPARE);
        good_frame(16'hFFFF, 3, 0);
    endtask

    task automatic test_frame_checks();
        good_frame(16'h0000, 0, 0);
        good_frame(16'($urandom), 4, 2);
        build_frame(FUNC_WRITE, SUB_DATA, 16'h0102, 16'd3, 3, 16'h8001);
        send_frame();
        build_frame(8'h03, SUB_DATA, 16'h0203, 16'd2, 2, 16'h0000);
        send_frame();
        build_frame(FUNC_WRITE, 8'h00, 16'h0304, 16'd2, 2, 16'h0000);
        send_frame();
        build_raw(1);
        send_frame();
        build_raw(2);
        send_frame();
        build_raw(8);
        send_frame();
        // declared length reaches into the crc bytes
        build_frame(FUNC_WRITE, SUB_DATA, 16'h0405, 16'd10, 0, 16'h0000);
        send_frame();
        build_frame(FUNC_WRITE, SUB_DATA, 16'h0506, 16'd6, 4, 16'h0000);
        send_frame();
        // timeout in the middle of a frame ends the download with a report
        build_frame(FUNC_WRITE, SUB_DATA, 16'h0607, 16'd5, 5, 16'h0000);
        cut_frame(9);
        send_event(MODE_START);
    endtask

    task automatic test_oversize();
        build_frame(FUNC_WRITE, SUB_DATA, 16'h7FFF, 16'(FRAME_MAX - MIN_FRAME),
                    FRAME_MAX - MIN_FRAME, 16'h0000);
        send_frame();
        build_frame(FUNC_WRITE, SUB_DATA, 16'h1111, 16'd4, FRAME_MAX + 1 - MIN_FRAME, 16'h0000);
        send_frame();
        build_frame(8'h10, SUB_DATA, 16'h2222, 16'd4, FRAME_MAX + 6 - MIN_FRAME, 16'h0000);
        send_frame();
        good_frame(16'h3333, 2, 0);
        send_event(MODE_TIMEOUT);
    endtask

    task automatic test_image_verdicts();
        wait_results_done();
        set_regs(8'hFF, 24'd0, 16'h0000, MAX24);
        send_event(MODE_START);
        good_frame(16'h1234, 5, 0);
        good_frame(16'h1235, 3, 1);
        wait_results_done();
        set_regs(8'hFF, img_bytes, img_crc_done, MAX24);
        send_event(MODE_TIMEOUT);

        wait_results_done();
        set_regs(8'h00, 24'd0, 16'h0000, 24'd1);
        send_event(MODE_START);
        good_frame(16'h2000, 4, 0);
        wait_results_done();
        set_regs(8'h00, img_bytes, ~img_crc_done, 24'd1);
        send_event(MODE_TIMEOUT);

        wait_results_done();
        set_regs(8'h5A, 24'd4, 16'h0000, 24'd1);
        send_event(MODE_START);
        good_frame(16'h3000, 4, 0);
        send_event(MODE_TIMEOUT);

        wait_results_done();
        set_regs(8'hA5, MAX24, 16'hFFFF, 24'd6);
        send_event(MODE_START);
        good_frame(16'h4000, 6, 0);
        send_event(MODE_TIMEOUT);

        wait_results_done();
        set_regs(8'h3C, 24'd0, 16'hFFFF, 24'd6);
        send_event(MODE_START);
        good_frame(16'h5000, 6, 0);
        send_event(MODE_TIMEOUT);
    endtask

    task automatic test_random_downloads(input int n_items);
        int goal;
        goal = sent_count + n_items;
        while (sent_count < goal) begin
            wait_results_done();
            if ($urandom_range(2) == 0)
                set_regs(rand_station(), 24'($urandom), 16'($urandom), rand_limit());
            else
                set_regs(rand_station(), 24'd0, 16'h0000, rand_limit());
            if ($urandom_range(4) == 0) send_event(MODE_TIMEOUT);
            send_event(MODE_START);
            repeat ($urandom_range(6, 1)) begin
                if ($urandom_range(9) == 0)
                    send_event($urandom_range(1) ? MODE_SPARE : MODE_START);
                random_frame();
            end
            if ($urandom_range(1)) begin
                wait_results_done();
                set_regs(reg_station,
                         ($urandom_range(3) == 0) ? img_bytes + 24'd1 : img_bytes,
                         ($urandom_range(3) == 0) ? img_crc_done ^ 16'h0100 : img_crc_done,
                         rand_limit());
            end
            send_event(MODE_TIMEOUT);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 26;
        rx_idle_pct = 88;
        test_idle_session();
        test_frame_checks();
        test_oversize();
        test_image_verdicts();
        test_random_downloads(150);

        wait_results_done();
        tx_idle_pct = 88;
        rx_idle_pct = 26;
        test_random_downloads(150);

        wait_results_done();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_downloads(150);

        wait_results_done();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
